// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ACS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acs assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ACS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acs assertion failed");

`endif

// ----- src/acs_pkg.sv -----
// Shared types and constants of the ambient-cancelling IR sequencer.
// No dependencies; imported by every module of the block.
package acs_pkg;

    // Default sample width of the ADC.
    localparam int SAMPLE_BITS_DEF = 12;

    // Item function codes.
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Samples per capture pair; count value that means the pair is complete.
    localparam logic [1:0] PAIR_LEN = 2'd2;

    // Capture buffer select.
    localparam logic TARGET_AMBIENT = 1'b0;
    localparam logic TARGET_LIT     = 1'b1;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_AMB_FIRST  = 3'd0,
        PH_AMB_SECOND = 3'd1,
        PH_EMIT_ON    = 3'd2,
        PH_SETTLE     = 3'd3,
        PH_LIT_FIRST  = 3'd4,
        PH_LIT_SECOND = 3'd5,
        PH_EMIT_OFF   = 3'd6,
        PH_CALC       = 3'd7
    } t_phase;

    // Commands from the sequencer to the capture and calculation units.
    typedef struct packed {
        logic arm;      // arm capture of the next two samples
        logic target;   // buffer to arm
        logic convert;  // conversion request pulse
        logic calc;     // compute the reading
    } t_seq_ctrl;

endpackage

// ----- src/ir_ambient_cancel_sequencer.sv -----
// Top level of the ambient-cancelling IR proximity sequencer.
// Depends on acs_pkg, acs_phase, acs_capture and acs_calc.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  input    | i_valid / o_ready  | i_func, i_sample
//  result   | o_valid / i_ready  | o_led_on, o_convert_start, o_capture_arm,
//           |                    | o_ir_value, o_phase, o_done_res
//
// One item per clock while o_ready is high: the state update for an item is done in the
// cycle it is accepted, and its result is loaded into the output register at that edge.
// o_valid rises in the cycle after acceptance.
// The output register is the only buffer: a new item is taken whenever the
// register is empty or its result is being taken in the same cycle.
// Reset (i_rst_n low, synchronous) clears phase, buffers, reading, flags and o_valid.
module ir_ambient_cancel_sequencer #(
    parameter int SAMPLE_BITS = acs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_func,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_led_on,
    output logic                   o_convert_start,
    output logic                   o_capture_arm,
    output logic [SAMPLE_BITS-1:0] o_ir_value,
    output logic [2:0]             o_phase,
    output logic                   o_done_res
);
    import acs_pkg::*;

    logic                        fire;
    t_seq_ctrl                   ctrl;
    t_phase                      n_phase;
    logic                        n_emitter, n_done, pair_done;
    logic [1:0][SAMPLE_BITS-1:0] ambient, lit;
    logic [SAMPLE_BITS-1:0]      n_ir;

    logic                        r_out_valid, n_out_valid;
    logic                        r_emitter, r_convert, r_arm, r_done;
    logic [SAMPLE_BITS-1:0]      r_ir;
    logic [2:0]                  r_phase;

    assign o_ready = !r_out_valid || i_ready;
    assign fire    = i_valid && o_ready;

    acs_phase u_phase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_func      (i_func),
        .i_pair_done (pair_done),
        .o_ctrl      (ctrl),
        .o_n_phase   (n_phase),
        .o_n_emitter (n_emitter),
        .o_n_done    (n_done)
    );

    acs_capture #(.SAMPLE_BITS(SAMPLE_BITS)) u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_func      (i_func),
        .i_sample    (i_sample),
        .i_ctrl      (ctrl),
        .o_pair_done (pair_done),
        .o_ambient   (ambient),
        .o_lit       (lit)
    );

    acs_calc #(.SAMPLE_BITS(SAMPLE_BITS)) u_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_ambient (ambient),
        .i_lit     (lit),
        .o_n_ir    (n_ir)
    );

    // Hold the result until taken; refill on every accepted item.
    assign n_out_valid = fire || (r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_emitter <= n_emitter;
            r_convert <= ctrl.convert;
            r_arm     <= ctrl.arm;
            r_ir      <= n_ir;
            r_phase   <= n_phase;
            r_done    <= n_done;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_led_on        = r_emitter;
    assign o_convert_start = r_convert;
    assign o_capture_arm   = r_arm;
    assign o_ir_value      = r_ir;
    assign o_phase         = r_phase;
    assign o_done_res      = r_done;

endmodule

// ----- src/acs_phase.sv -----
// Phase sequencer: phase register, emitter level and done flag.
// Depends on acs_pkg.
module acs_phase (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [1:0]         i_func,
    input  logic               i_pair_done,
    output acs_pkg::t_seq_ctrl o_ctrl,
    output acs_pkg::t_phase    o_n_phase,
    output logic               o_n_emitter,
    output logic               o_n_done
);
    import acs_pkg::*;

    t_phase    r_phase, n_phase;
    logic      r_emitter, n_emitter;
    logic      r_done, n_done;
    t_seq_ctrl ctrl;
    logic      tick;

    assign tick = i_fire && (i_func == FUNC_TICK);

    // Advance the phase on a tick, holding first-sample phases until the pair is in; restart returns to PH_AMB_FIRST.
    always_comb begin
        n_phase = r_phase;
        if (i_fire && (i_func == FUNC_RESTART)) begin
            n_phase = PH_AMB_FIRST;
        end else if (tick) begin
            case (r_phase)
                PH_AMB_FIRST:  if (i_pair_done) n_phase = PH_AMB_SECOND;
                PH_AMB_SECOND: n_phase = PH_EMIT_ON;
                PH_EMIT_ON:    n_phase = PH_SETTLE;
                PH_SETTLE:     n_phase = PH_LIT_FIRST;
                PH_LIT_FIRST:  if (i_pair_done) n_phase = PH_LIT_SECOND;
                PH_LIT_SECOND: n_phase = PH_EMIT_OFF;
                PH_EMIT_OFF:   n_phase = PH_CALC;
                default:       n_phase = PH_CALC;
            endcase
        end
    end

    // Drive pulses, emitter and done for this item.
    always_comb begin
        ctrl      = '0;
        n_emitter = r_emitter;
        n_done    = r_done;
        if (i_fire && (i_func == FUNC_RESTART)) begin
            n_emitter = 1'b0;
            n_done    = 1'b0;
        end else if (tick) begin
            case (r_phase)
                PH_AMB_FIRST, PH_LIT_FIRST: begin
                    ctrl.arm     = i_pair_done;
                    ctrl.convert = i_pair_done;
                    ctrl.target  = (r_phase == PH_LIT_FIRST) ? TARGET_LIT : TARGET_AMBIENT;
                end
                PH_AMB_SECOND, PH_LIT_SECOND: ctrl.convert = 1'b1;
                PH_EMIT_ON:  n_emitter = 1'b1;
                PH_EMIT_OFF: n_emitter = 1'b0;
                PH_CALC: begin
                    ctrl.calc = 1'b1;
                    n_done    = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_AMB_FIRST;
            r_emitter <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_emitter <= n_emitter;
            r_done    <= n_done;
        end
    end

    assign o_ctrl      = ctrl;
    assign o_n_phase   = n_phase;
    assign o_n_emitter = n_emitter;
    assign o_n_done    = n_done;

endmodule

// ----- src/acs_capture.sv -----
// Sample capture: ambient and lit pair buffers with their write pointer.
// Depends on acs_pkg.
module acs_capture #(
    parameter int SAMPLE_BITS = acs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic [1:0]                        i_func,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    input  acs_pkg::t_seq_ctrl                i_ctrl,
    output logic                              o_pair_done,
    output logic [1:0][SAMPLE_BITS-1:0]       o_ambient,
    output logic [1:0][SAMPLE_BITS-1:0]       o_lit
);
    import acs_pkg::*;

    logic                        r_target;
    logic [1:0]                  r_count;
    logic [1:0][SAMPLE_BITS-1:0] r_ambient;
    logic [1:0][SAMPLE_BITS-1:0] r_lit;
    logic                        take;

    assign o_pair_done = (r_count >= PAIR_LEN);
    assign take        = i_fire && (i_func == FUNC_SAMPLE) && !o_pair_done;

    // Arm on the sequencer's request; store samples while the pair is open.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= TARGET_AMBIENT;
            r_count   <= PAIR_LEN;
            r_ambient <= '0;
            r_lit     <= '0;
        end else if (i_ctrl.arm) begin
            r_target <= i_ctrl.target;
            r_count  <= '0;
        end else if (take) begin
            if (r_target == TARGET_LIT) begin
                r_lit[r_count[0]] <= i_sample;
            end else begin
                r_ambient[r_count[0]] <= i_sample;
            end
            r_count <= r_count + 2'd1;
        end
    end

    assign o_ambient = r_ambient;
    assign o_lit     = r_lit;

endmodule

// ----- src/acs_calc.sv -----
// Reading calculation: pair averages, difference clamped at zero, result register.
// Depends on acs_pkg.
module acs_calc #(
    parameter int SAMPLE_BITS = acs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  acs_pkg::t_seq_ctrl          i_ctrl,
    input  logic [1:0][SAMPLE_BITS-1:0] i_ambient,
    input  logic [1:0][SAMPLE_BITS-1:0] i_lit,
    output logic [SAMPLE_BITS-1:0]      o_n_ir
);
    import acs_pkg::*;

    logic [SAMPLE_BITS-1:0] r_ir, n_ir;
    logic [SAMPLE_BITS:0]   amb_sum, lit_sum;
    logic [SAMPLE_BITS-1:0] amb_avg, lit_avg;

    // Average each pair, then subtract and clamp.
    always_comb begin
        amb_sum = {1'b0, i_ambient[0]} + {1'b0, i_ambient[1]};
        lit_sum = {1'b0, i_lit[0]} + {1'b0, i_lit[1]};
        amb_avg = amb_sum[SAMPLE_BITS:1];
        lit_avg = lit_sum[SAMPLE_BITS:1];
        n_ir    = r_ir;
        if (i_ctrl.calc) begin
            n_ir = (lit_avg > amb_avg) ? (lit_avg - amb_avg) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir <= '0;
        end else begin
            r_ir <= n_ir;
        end
    end

    assign o_n_ir = n_ir;

endmodule

// ----- src/acs_checker.sv -----
// Port-level checker for the IR sequencer, attached to the top level by bind.
// Depends on acs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module acs_checker #(
    parameter int SAMPLE_BITS = acs_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic                   o_led_on,
    input logic                   o_convert_start,
    input logic                   o_capture_arm,
    input logic [SAMPLE_BITS-1:0] o_ir_value,
    input logic [2:0]             o_phase,
    input logic                   o_done_res
);
    import acs_pkg::*;

    logic stalled;
    logic second_phase;
    logic lit_window;

    assign stalled      = o_valid && !i_ready;
    assign second_phase = (o_phase == PH_AMB_SECOND) || (o_phase == PH_LIT_SECOND);
    assign lit_window   = (o_phase == PH_SETTLE) || (o_phase == PH_LIT_FIRST)
                       || (o_phase == PH_LIT_SECOND) || (o_phase == PH_EMIT_OFF);

    // Stalled result holds.
    `ACS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, stalled, o_valid && $stable({o_ir_value, o_phase}))

    // Arming always comes with a conversion request and lands in a second-sample phase.
    `ACS_ASSERT_NOW(a_arm, i_clk, i_rst_n, o_valid && o_capture_arm, o_convert_start && second_phase)

    // Done only in the calculate phase, with the emitter off.
    `ACS_ASSERT_NOW(a_done, i_clk, i_rst_n, o_valid && o_done_res, o_phase == PH_CALC && !o_led_on)

    // Emitter is lit only between turn-on and turn-off.
    `ACS_ASSERT_NOW(a_emit, i_clk, i_rst_n, o_valid && o_led_on, lit_window)

endmodule

bind ir_ambient_cancel_sequencer acs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_acs_checker (.*);
